// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file lqe_checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset masks the check.
`define LQE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset masks the check.
`define LQE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/lqe_pkg.sv
// Types, constants and helper functions for the line to quad expander.
// No dependencies.
package lqe_pkg;

  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned UNIT_BITS = 16;
  localparam int unsigned FIFO_DEPTH = 2;

  localparam logic [1:0] REG_LINE_WIDTH = 2'd0;
  localparam logic [1:0] REG_SCALE_X    = 2'd1;
  localparam logic [1:0] REG_SCALE_Y    = 2'd2;

  localparam logic [11:0] CFG_RESET = 12'(1 << FRAC_BITS);

  typedef enum logic [3:0] {
    F_IDLE, F_SCALE, F_SQUARE, F_CLASS, F_NORM, F_SQRT,
    F_DINIT, F_DIV, F_EXT, F_CORNER, F_PUSH
  } front_state_e;

  typedef struct packed {
    logic [11:0] line_width;
    logic [11:0] scale_x;
    logic [11:0] scale_y;
  } cfg_t;

  typedef struct packed {
    logic [23:0] y;
    logic [23:0] x;
  } corner_t;

  typedef struct packed {
    corner_t [3:0] c;
    logic [7:0]    intensity;
    logic          dot;
  } quad_t;

  // Shift right with rounding to nearest, ties away from zero.
  function automatic logic signed [63:0] shr_rnd(input logic signed [63:0] v,
                                                 input int unsigned s);
    logic [63:0] m;
    if (s == 0) return v;
    m = v[63] ? 64'(-v) : 64'(v);
    m = (m + (64'd1 << (s - 1))) >> s;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [23:0] sat24(input logic signed [25:0] v);
    if (v > 26'sd8388607) return 24'h7FFFFF;
    if (v < -26'sd8388608) return 24'h800000;
    return v[23:0];
  endfunction

  // Vertex order a,b,c,c,d,a.
  function automatic logic [1:0] corner_sel(input logic [2:0] pos);
    case (pos)
      3'd0: return 2'd0;
      3'd1: return 2'd1;
      3'd2: return 2'd2;
      3'd3: return 2'd2;
      3'd4: return 2'd3;
      default: return 2'd0;
    endcase
  endfunction

endpackage

// File: rtl/core/lqe_front.sv
// Front end: input holding register and iterative quad geometry engine.
// Depends on lqe_pkg.
module lqe_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lqe_pkg::cfg_t  cfg_i,
  input  logic           push,
  output logic           full,
  input  logic [15:0]    start_x_i,
  input  logic [15:0]    start_y_i,
  input  logic [15:0]    end_x_i,
  input  logic [15:0]    end_y_i,
  input  logic [7:0]     intensity_i,
  output logic           q_push_o,
  output lqe_pkg::quad_t q_data_o,
  input  logic           q_full_i
);
  import lqe_pkg::*;

  localparam logic signed [23:0] ONE = 24'sd1 <<< FRAC_BITS;

  front_state_e state_q, state_d;
  logic in_vld_q, take;

  logic [15:0] in_sx0_q, in_sy0_q, in_sx1_q, in_sy1_q;
  logic [7:0]  in_int_q;

  logic signed [15:0] sx0_q, sy0_q, sx1_q, sy1_q;
  logic [7:0]         int_q;
  logic signed [23:0] x0_q, y0_q, x1_q, y1_q, vx_q, vy_q, ox_q, oy_q;
  logic signed [16:0] dx_q, dy_q;
  logic [34:0]        d2_q;
  logic [61:0]        len2_q, res_q;
  logic [4:0]         k_q, cnt_q;
  logic [30:0]        remx_q, remy_q;
  logic [17:0]        shx_q, shy_q, qx_q, qy_q;
  logic               dot_q;
  quad_t              quad_q;

  // datapath terms
  logic [11:0]        lw;
  logic signed [28:0] px0, py0, px1, py1;
  logic signed [33:0] dxx, dyy;
  logic signed [47:0] vxx, vyy;
  logic [41:0]        d2h;
  logic [61:0]        sq_bit, sq_try;
  logic [30:0]        len;
  logic [22:0]        ax, ay;
  logic [66:0]        numx, numy;
  logic [31:0]        rx2, ry2;
  logic               gex, gey;
  logic signed [18:0] nx, ny;
  logic signed [19:0] nny;
  logic signed [32:0] pox, poy;
  logic [12:0]        hh;
  logic signed [25:0] h26;

  assign lw  = (cfg_i.line_width < 12'(1 << FRAC_BITS)) ? 12'(1 << FRAC_BITS)
                                                         : cfg_i.line_width;
  assign px0 = sx0_q * $signed({1'b0, cfg_i.scale_x});
  assign px1 = sx1_q * $signed({1'b0, cfg_i.scale_x});
  assign py0 = sy0_q * $signed({1'b0, cfg_i.scale_y});
  assign py1 = sy1_q * $signed({1'b0, cfg_i.scale_y});
  assign dxx = dx_q * dx_q;
  assign dyy = dy_q * dy_q;
  assign vxx = vx_q * vx_q;
  assign vyy = vy_q * vy_q;
  assign d2h = 42'(d2_q) * 42'd100;
  assign sq_bit = 62'd1 << {cnt_q, 1'b0};
  assign sq_try = res_q + sq_bit;
  assign len = res_q[30:0];
  assign ax  = vx_q[23] ? 23'(-vx_q) : 23'(vx_q);
  assign ay  = vy_q[23] ? 23'(-vy_q) : 23'(vy_q);
  assign numx = (67'(ax) << (UNIT_BITS + 32'(k_q))) + 67'(len >> 1);
  assign numy = (67'(ay) << (UNIT_BITS + 32'(k_q))) + 67'(len >> 1);
  assign rx2 = {remx_q, shx_q[17]};
  assign ry2 = {remy_q, shy_q[17]};
  assign gex = rx2 >= {1'b0, len};
  assign gey = ry2 >= {1'b0, len};
  assign nx  = vx_q[23] ? -$signed({1'b0, qx_q}) : $signed({1'b0, qx_q});
  assign ny  = vy_q[23] ? -$signed({1'b0, qy_q}) : $signed({1'b0, qy_q});
  assign nny = -20'(ny);
  assign pox = nny * $signed({2'b0, lw});
  assign poy = 20'(nx) * $signed({2'b0, lw});
  assign hh  = ({1'b0, lw} + 13'd1) >> 1;
  assign h26 = $signed({13'd0, hh});

  // input holding register
  assign full = in_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (push && !in_vld_q) begin
      in_vld_q <= 1'b1;
    end else if (take) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && !in_vld_q) begin
      in_sx0_q <= start_x_i;
      in_sy0_q <= start_y_i;
      in_sx1_q <= end_x_i;
      in_sy1_q <= end_y_i;
      in_int_q <= intensity_i;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE:   if (in_vld_q) state_d = F_SCALE;
      F_SCALE:  state_d = F_SQUARE;
      F_SQUARE: state_d = F_CLASS;
      F_CLASS: begin
        if ((d2h <= (42'd1 << (2 * FRAC_BITS))) || (vx_q == 0 && vy_q == 0)) begin
          state_d = F_CORNER;
        end else begin
          state_d = F_NORM;
        end
      end
      F_NORM:   if (len2_q >= (62'd1 << 60)) state_d = F_SQRT;
      F_SQRT:   if (cnt_q == 5'd0) state_d = F_DINIT;
      F_DINIT:  state_d = F_DIV;
      F_DIV:    if (cnt_q == 5'd0) state_d = F_EXT;
      F_EXT:    state_d = F_CORNER;
      F_CORNER: state_d = F_PUSH;
      F_PUSH:   if (!q_full_i) state_d = F_IDLE;
      default:  state_d = F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    take     = 1'b0;
    q_push_o = 1'b0;
    case (state_q)
      F_IDLE:  take = in_vld_q;
      F_PUSH:  q_push_o = !q_full_i;
      default: ;
    endcase
  end

  assign q_data_o = quad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      F_IDLE: begin
        sx0_q <= $signed(in_sx0_q);
        sy0_q <= $signed(in_sy0_q);
        sx1_q <= $signed(in_sx1_q);
        sy1_q <= $signed(in_sy1_q);
        int_q <= in_int_q;
      end
      F_SCALE: begin
        x0_q <= 24'(shr_rnd(64'(px0), FRAC_BITS));
        y0_q <= 24'(shr_rnd(64'(py0), FRAC_BITS));
        x1_q <= 24'(shr_rnd(64'(px1), FRAC_BITS));
        y1_q <= 24'(shr_rnd(64'(py1), FRAC_BITS));
        dx_q <= 17'(sx1_q) - 17'(sx0_q);
        dy_q <= 17'(sy1_q) - 17'(sy0_q);
      end
      F_SQUARE: begin
        d2_q <= 35'($unsigned(dxx)) + 35'($unsigned(dyy));
        vx_q <= x1_q - x0_q;
        vy_q <= y1_q - y0_q;
      end
      F_CLASS: begin
        dot_q  <= (d2h <= (42'd1 << (2 * FRAC_BITS))) || (vx_q == 0 && vy_q == 0);
        len2_q <= 62'($unsigned(vxx)) + 62'($unsigned(vyy));
        k_q    <= 5'd0;
      end
      F_NORM: begin
        if (len2_q >= (62'd1 << 60)) begin
          res_q <= 62'd0;
          cnt_q <= 5'd30;
        end else if (len2_q[61:54] == 8'd0) begin
          len2_q <= len2_q << 8;
          k_q    <= k_q + 5'd4;
        end else begin
          len2_q <= len2_q << 2;
          k_q    <= k_q + 5'd1;
        end
      end
      F_SQRT: begin
        if (len2_q >= sq_try) begin
          len2_q <= len2_q - sq_try;
          res_q  <= (res_q >> 1) + sq_bit;
        end else begin
          res_q  <= res_q >> 1;
        end
        cnt_q <= cnt_q - 5'd1;
      end
      F_DINIT: begin
        remx_q <= numx[48:18];
        remy_q <= numy[48:18];
        shx_q  <= numx[17:0];
        shy_q  <= numy[17:0];
        qx_q   <= 18'd0;
        qy_q   <= 18'd0;
        cnt_q  <= 5'd17;
      end
      F_DIV: begin
        remx_q <= gex ? 31'(rx2 - {1'b0, len}) : 31'(rx2);
        remy_q <= gey ? 31'(ry2 - {1'b0, len}) : 31'(ry2);
        qx_q   <= {qx_q[16:0], gex};
        qy_q   <= {qy_q[16:0], gey};
        shx_q  <= shx_q << 1;
        shy_q  <= shy_q << 1;
        cnt_q  <= cnt_q - 5'd1;
      end
      F_EXT: begin
        // push the end out so a short axis still covers one pixel
        if (vx_q > -ONE && vx_q < ONE) begin
          x1_q <= x0_q + 24'(shr_rnd(64'(nx), UNIT_BITS - FRAC_BITS));
        end
        if (vy_q > -ONE && vy_q < ONE) begin
          y1_q <= y0_q + 24'(shr_rnd(64'(ny), UNIT_BITS - FRAC_BITS));
        end
        ox_q <= 24'(shr_rnd(64'(pox), UNIT_BITS + 1));
        oy_q <= 24'(shr_rnd(64'(poy), UNIT_BITS + 1));
      end
      F_CORNER: begin
        quad_q.intensity <= int_q;
        quad_q.dot       <= dot_q;
        if (dot_q) begin
          quad_q.c[0].x <= sat24(26'(x0_q) + h26);
          quad_q.c[0].y <= sat24(26'(y0_q) + h26);
          quad_q.c[1].x <= sat24(26'(x0_q) + h26);
          quad_q.c[1].y <= sat24(26'(y0_q) - h26);
          quad_q.c[2].x <= sat24(26'(x0_q) - h26);
          quad_q.c[2].y <= sat24(26'(y0_q) - h26);
          quad_q.c[3].x <= sat24(26'(x0_q) - h26);
          quad_q.c[3].y <= sat24(26'(y0_q) + h26);
        end else begin
          quad_q.c[0].x <= sat24(26'(x0_q) + 26'(ox_q));
          quad_q.c[0].y <= sat24(26'(y0_q) + 26'(oy_q));
          quad_q.c[1].x <= sat24(26'(x0_q) - 26'(ox_q));
          quad_q.c[1].y <= sat24(26'(y0_q) - 26'(oy_q));
          quad_q.c[2].x <= sat24(26'(x1_q) - 26'(ox_q));
          quad_q.c[2].y <= sat24(26'(y1_q) - 26'(oy_q));
          quad_q.c[3].x <= sat24(26'(x1_q) + 26'(ox_q));
          quad_q.c[3].y <= sat24(26'(y1_q) + 26'(oy_q));
        end
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/core/lqe_fifo.sv
// Short queue of finished quads between front and back.
// Depends on lqe_pkg.
module lqe_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lqe_pkg::quad_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output lqe_pkg::quad_t data_o,
  output logic           empty_o
);
  import lqe_pkg::*;

  quad_t      mem_q [FIFO_DEPTH];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'(FIFO_DEPTH);
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

// File: rtl/core/lqe_back.sv
// Back end: holds one quad and emits its six vertices.
// Depends on lqe_pkg.
module lqe_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lqe_pkg::quad_t q_data_i,
  input  logic           q_empty_i,
  output logic           q_pop_o,
  output logic           empty,
  input  logic           pop,
  output logic [23:0]    vert_x_o,
  output logic [23:0]    vert_y_o,
  output logic [7:0]     vert_intensity_o,
  output logic           is_dot_o,
  output logic           last_vertex_o
);
  import lqe_pkg::*;

  quad_t      cur_q;
  logic       vld_q;
  logic [2:0] pos_q;
  logic       done;
  corner_t    sel;

  assign done    = pop && vld_q && pos_q == 3'd5;
  assign q_pop_o = !q_empty_i && (!vld_q || done);
  assign sel     = cur_q.c[corner_sel(pos_q)];

  assign empty            = !vld_q;
  assign vert_x_o         = sel.x;
  assign vert_y_o         = sel.y;
  assign vert_intensity_o = cur_q.intensity;
  assign is_dot_o         = cur_q.dot;
  assign last_vertex_o    = pos_q == 3'd5;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      pos_q <= 3'd0;
    end else if (q_pop_o) begin
      vld_q <= 1'b1;
      pos_q <= 3'd0;
    end else if (done) begin
      vld_q <= 1'b0;
      pos_q <= 3'd0;
    end else if (pop && vld_q) begin
      pos_q <= pos_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) cur_q <= q_data_i;
  end

endmodule

// File: rtl/core/line_to_quad_expander.sv
// Line to quad expander: one line in, six quad vertices out.
// Throughput is bound by the 31-step square root and the 18-step divider of the
// front engine; the input register can take the next line while one is computed,
// and dots are bound by the back end, which emits six vertices per quad.
// Reset: rst_ni is asynchronous, active low; queues empty, registers at 1.0.
// Depends on lqe_pkg, lqe_front, lqe_fifo, lqe_back.
module line_to_quad_expander (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config port, APB style
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // line input
  input  logic        push,
  output logic        full,
  input  logic [15:0] start_x_i,
  input  logic [15:0] start_y_i,
  input  logic [15:0] end_x_i,
  input  logic [15:0] end_y_i,
  input  logic [7:0]  intensity_i,
  // vertex output
  output logic        empty,
  input  logic        pop,
  output logic [23:0] vert_x_o,
  output logic [23:0] vert_y_o,
  output logic [7:0]  vert_intensity_o,
  output logic        is_dot_o,
  output logic        last_vertex_o
);
  import lqe_pkg::*;

  cfg_t       cfg_q;
  logic [1:0] reg_idx;
  logic       wr_en;

  logic  f_push, f_full, f_pop, f_empty;
  quad_t f_wdata, f_rdata;

  // Registers at word addresses; a write lands on the access phase.
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_width <= CFG_RESET;
      cfg_q.scale_x    <= CFG_RESET;
      cfg_q.scale_y    <= CFG_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_LINE_WIDTH: cfg_q.line_width <= pwdata[11:0];
        REG_SCALE_X:    cfg_q.scale_x    <= pwdata[11:0];
        REG_SCALE_Y:    cfg_q.scale_y    <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LINE_WIDTH: prdata = {20'd0, cfg_q.line_width};
      REG_SCALE_X:    prdata = {20'd0, cfg_q.scale_x};
      REG_SCALE_Y:    prdata = {20'd0, cfg_q.scale_y};
      default:        prdata = 32'd0;
    endcase
  end

  // Front: holds one incoming item and computes its four corners.
  lqe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .push        (push),
    .full        (full),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .intensity_i (intensity_i),
    .q_push_o    (f_push),
    .q_data_o    (f_wdata),
    .q_full_i    (f_full)
  );

  // Two-entry queue so the back end can drain while the front computes.
  lqe_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  (f_wdata),
    .full_o  (f_full),
    .pop_i   (f_pop),
    .data_o  (f_rdata),
    .empty_o (f_empty)
  );

  // Back: emits a,b,c,c,d,a, one vertex per pop.
  lqe_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_data_i         (f_rdata),
    .q_empty_i        (f_empty),
    .q_pop_o          (f_pop),
    .empty            (empty),
    .pop              (pop),
    .vert_x_o         (vert_x_o),
    .vert_y_o         (vert_y_o),
    .vert_intensity_o (vert_intensity_o),
    .is_dot_o         (is_dot_o),
    .last_vertex_o    (last_vertex_o)
  );

endmodule

// File: rtl/core/lqe_checker.sv
// Port-level checks for the line to quad expander, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module lqe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        psel,
  input logic        pready,
  input logic        empty,
  input logic        pop,
  input logic [23:0] vert_x_o,
  input logic [23:0] vert_y_o,
  input logic [7:0]  vert_intensity_o,
  input logic        is_dot_o,
  input logic        last_vertex_o
);

  // a waiting vertex holds until taken
  `LQE_ASSERT_NXT(a_hold, !empty && !pop, !empty && $stable(vert_x_o) && $stable(vert_y_o), "vertex changed while stalled")

  // within one quad the rest of the run follows at once with the same attributes
  `LQE_ASSERT_NXT(a_run, !empty && pop && !last_vertex_o, !empty && $stable(is_dot_o) && $stable(vert_intensity_o), "quad run broken")

  `LQE_ASSERT_IMP(a_ready, psel, pready, "config port not ready")

endmodule

bind line_to_quad_expander lqe_checker u_lqe_checker (.*);

// File: dv/tb_top.sv
// Self-checking testbench for line_to_quad_expander: drives lines, predicts six vertices each.
// Depends on lqe_pkg (register indexes and constants) and the line_to_quad_expander RTL.
`timescale 1ns / 100ps

module tb_top;
  import lqe_pkg::*;

  localparam int CLK_HALF   = 2;
  localparam int DRAIN_WAIT = 100;  // covers the line latency
  localparam int WDOG_LIMIT = 5000; // no-handshake cycles before giving up
  localparam int HOLD_LEN   = 400;  // long receiver hold-off

  logic        clk_i, rst_ni;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        push, full, empty, pop;
  logic [15:0] start_x_i, start_y_i, end_x_i, end_y_i;
  logic [7:0]  intensity_i;
  logic [23:0] vert_x_o, vert_y_o;
  logic [7:0]  vert_intensity_o;
  logic        is_dot_o, last_vertex_o;

  line_to_quad_expander i_dut (.*);

  // One expected vertex.
  typedef struct {
    logic [23:0] x;
    logic [23:0] y;
    logic [7:0]  inten;
    logic        dot;
    logic        last;
  } vertex_t;

  // Directed line; when typed is set, vertex a is known by hand.
  typedef struct {
    logic [15:0] sx, sy, ex, ey;
    logic [7:0]  inten;
    bit          typed;
    logic [23:0] ax, ay;
  } line_row_t;

  vertex_t     vertex_q[$];
  logic [11:0] width_sh, scale_x_sh, scale_y_sh;
  int          errors, lines_sent, verts_seen, dots_seen, idle_cycles;
  int          send_idle_pct, stall_pct;
  bit          hold_off;
  logic [23:0] last_ax, last_ay;

  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  task automatic report(input string what, input logic [23:0] got, input logic [23:0] want);
    errors++;
    $display("MISMATCH %s: got %0h expected %0h (vertex %0d)", what, got, want, verts_seen);
  endtask

  // Rounding shift, ties away from zero.
  function automatic longint rnd_shift(input longint v, input int s);
    longint unsigned m;
    if (s == 0) return v;
    m = v < 0 ? -v : v;
    m = (m + (64'd1 << (s - 1))) >> s;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint rnd_div(input longint num, input longint den);
    longint unsigned m;
    m = num < 0 ? -num : num;
    m = (m + den / 2) / den;
    return num < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   -= res + bitv;
        res  = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [23:0] clip24(input longint v);
    if (v > 8388607) return 24'h7FFFFF;
    if (v < -8388608) return 24'h800000;
    return v[23:0];
  endfunction

  // Expands one line into its six vertices and queues them.
  task automatic expand_line(input logic [15:0] sx_r, sy_r, ex_r, ey_r,
                             input logic [7:0] inten);
    longint sx, sy, ex, ey, one, lw, dx, dy, x0, y0, x1, y1, vx, vy, h;
    longint len, nx, ny, ox, oy;
    longint unsigned d2, len2;
    longint cx[4], cy[4];
    int k;
    bit dot;
    int sel[6] = '{0, 1, 2, 2, 3, 0};
    vertex_t v;
    sx = $signed(sx_r); sy = $signed(sy_r);
    ex = $signed(ex_r); ey = $signed(ey_r);
    one = 64'd1 << FRAC_BITS;
    lw  = width_sh < one ? one : longint'(width_sh);
    dx  = ex - sx;
    dy  = ey - sy;
    d2  = dx * dx + dy * dy;
    // within 0.1 unscaled: square dot
    dot = 100 * d2 <= (64'd1 << (2 * FRAC_BITS));
    x0 = rnd_shift(sx * scale_x_sh, FRAC_BITS);
    y0 = rnd_shift(sy * scale_y_sh, FRAC_BITS);
    x1 = rnd_shift(ex * scale_x_sh, FRAC_BITS);
    y1 = rnd_shift(ey * scale_y_sh, FRAC_BITS);
    vx = x1 - x0;
    vy = y1 - y0;
    if (vx == 0 && vy == 0) dot = 1; // collapsed by scaling
    if (dot) begin
      h = rnd_shift(lw, 1);
      cx[0] = x0 + h; cy[0] = y0 + h;
      cx[1] = x0 + h; cy[1] = y0 - h;
      cx[2] = x0 - h; cy[2] = y0 - h;
      cx[3] = x0 - h; cy[3] = y0 + h;
    end else begin
      len2 = vx * vx + vy * vy;
      k = 0;
      while (len2 < (64'd1 << 60)) begin
        len2 <<= 2;
        k++;
      end
      len = floor_sqrt(len2);
      nx = rnd_div(vx * (64'sd1 <<< (UNIT_BITS + k)), len);
      ny = rnd_div(vy * (64'sd1 <<< (UNIT_BITS + k)), len);
      // sub-pixel axes get stretched to one pixel along the direction
      if (vx > -one && vx < one) x1 = x0 + rnd_shift(nx, UNIT_BITS - FRAC_BITS);
      if (vy > -one && vy < one) y1 = y0 + rnd_shift(ny, UNIT_BITS - FRAC_BITS);
      ox = rnd_shift(-ny * lw, UNIT_BITS + 1);
      oy = rnd_shift(nx * lw, UNIT_BITS + 1);
      cx[0] = x0 + ox; cy[0] = y0 + oy;
      cx[1] = x0 - ox; cy[1] = y0 - oy;
      cx[2] = x1 - ox; cy[2] = y1 - oy;
      cx[3] = x1 + ox; cy[3] = y1 + oy;
    end
    for (int i = 0; i < 6; i++) begin
      v.x     = clip24(cx[sel[i]]);
      v.y     = clip24(cy[sel[i]]);
      v.inten = inten;
      v.dot   = dot;
      v.last  = (i == 5);
      vertex_q = {vertex_q, v};
    end
    last_ax = clip24(cx[0]);
    last_ay = clip24(cy[0]);
    if (dot) dots_seen++;
  endtask

  // Offers one line, waits for acceptance, then predicts it.
  task automatic send_line(input logic [15:0] sx, sy, ex, ey, input logic [7:0] inten);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push        <= 1'b1;
    start_x_i   <= sx;
    start_y_i   <= sy;
    end_x_i     <= ex;
    end_y_i     <= ey;
    intensity_i <= inten;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    lines_sent++;
    expand_line(sx, sy, ex, ey, inten);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (vertex_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // APB write: setup then access cycle.
  task automatic reg_write(input logic [1:0] idx, input logic [11:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {20'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_LINE_WIDTH: width_sh   = val;
      REG_SCALE_X:    scale_x_sh = val;
      REG_SCALE_Y:    scale_y_sh = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [11:0] w, sxv, syv);
    reg_write(REG_LINE_WIDTH, w);
    reg_write(REG_SCALE_X, sxv);
    reg_write(REG_SCALE_Y, syv);
  endtask

  // Random line: mostly real segments, some short ones and dots.
  task automatic random_line();
    logic [15:0] sx, sy, ex, ey;
    int pick;
    sx = $urandom; sy = $urandom;
    pick = $urandom_range(9);
    if (pick < 4) begin
      ex = $urandom; ey = $urandom;
    end else if (pick < 7) begin
      ex = sx + 16'($urandom_range(600)) - 16'd300;
      ey = sy + 16'($urandom_range(600)) - 16'd300;
    end else if (pick < 9) begin
      ex = sx + 16'($urandom_range(50)) - 16'd25;
      ey = sy + 16'($urandom_range(50)) - 16'd25;
    end else begin
      ex = sx; ey = sy;
    end
    send_line(sx, sy, ex, ey, 8'($urandom));
  endtask

  // Result side: compare each accepted vertex with the oldest prediction.
  always @(posedge clk_i) begin
    vertex_t want;
    if (rst_ni && pop && !empty) begin
      if (vertex_q.size() == 0) begin
        report("unpredicted vertex x", vert_x_o, 24'd0);
      end else begin
        want = vertex_q.pop_front();
        if (vert_x_o !== want.x) report("vert_x", vert_x_o, want.x);
        if (vert_y_o !== want.y) report("vert_y", vert_y_o, want.y);
        if (vert_intensity_o !== want.inten)
          report("intensity", 24'(vert_intensity_o), 24'(want.inten));
        if (is_dot_o !== want.dot) report("is_dot", 24'(is_dot_o), 24'(want.dot));
        if (last_vertex_o !== want.last)
          report("last_vertex", 24'(last_vertex_o), 24'(want.last));
      end
      verts_seen++;
    end
    pop <= !hold_off && ($urandom_range(99) >= stall_pct);
  end

  // Watchdog on cycles with no handshake at all.
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || (psel && penable))
      idle_cycles <= 0;
    else if (idle_cycles >= WDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", idle_cycles);
      $display("line_to_quad_expander test failed");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  line_row_t dir_tab[$];
  int idle_set[4][2] = '{'{0, 0}, '{79, 0}, '{0, 79}, '{15, 15}};

  initial begin
    errors = 0; lines_sent = 0; verts_seen = 0; dots_seen = 0; idle_cycles = 0;
    send_idle_pct = 0; stall_pct = 0; hold_off = 0;
    width_sh = CFG_RESET; scale_x_sh = CFG_RESET; scale_y_sh = CFG_RESET;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    push = 0; pop = 0;
    start_x_i = '0; start_y_i = '0; end_x_i = '0; end_y_i = '0; intensity_i = '0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed lines at reset registers (width 1.0, scale 1.0).
    dir_tab = '{
      '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'hFF, 1, 24'd128, 24'd128},
      '{16'h0000, 16'h0000, 16'h0100, 16'h0000, 8'h00, 1, 24'd0,   24'd128},
      '{16'h0000, 16'h0000, 16'h0000, 16'h0100, 8'h5A, 1, -24'sd128, 24'd0},
      '{16'h0000, 16'h0000, 16'd25,   16'h0000, 8'h01, 0, 0, 0}, // just inside 0.1
      '{16'h0000, 16'h0000, 16'd26,   16'h0000, 8'h02, 0, 0, 0}, // just outside
      '{16'h0000, 16'h0000, 16'd64,   16'd0,    8'h80, 0, 0, 0}, // sub-pixel x
      '{16'h0010, 16'h0020, 16'h0030, 16'h0050, 8'h7F, 0, 0, 0}, // both axes short
      '{16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 8'hFF, 0, 0, 0},
      '{16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 8'hAA, 0, 0, 0},
      '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 8'h55, 1, 24'h807F, 24'h807F},
      '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 8'h33, 1, -24'sd32640, -24'sd32640},
      '{16'hFFFF, 16'h0001, 16'h0500, 16'hFB00, 8'hC3, 0, 0, 0}
    };
    foreach (dir_tab[i]) begin
      send_line(dir_tab[i].sx, dir_tab[i].sy, dir_tab[i].ex, dir_tab[i].ey, dir_tab[i].inten);
      if (dir_tab[i].typed) begin
        if (last_ax !== dir_tab[i].ax) report("hand vertex a x", last_ax, dir_tab[i].ax);
        if (last_ay !== dir_tab[i].ay) report("hand vertex a y", last_ay, dir_tab[i].ay);
      end
    end
    drain();

    // Zero scale collapses every line into a dot; zero width gets clamped.
    set_regs(12'd0, 12'd0, 12'd0);
    send_line(16'h8000, 16'h0000, 16'h7FFF, 16'h1234, 8'h11);
    send_line(16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h22);
    drain();
    set_regs(12'd0, 12'd0, 12'd4095); // only y survives scaling
    send_line(16'h0000, 16'h0000, 16'h4000, 16'h0001, 8'h44);
    send_line(16'h0000, 16'h0000, 16'h4000, 16'h0000, 8'h45);
    drain();
    set_regs(12'd4095, 12'd4095, 12'd4095);
    send_line(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 8'hFE);
    send_line(16'h7FFF, 16'h0000, 16'h7FFF, 16'h0000, 8'hFD);
    drain();

    // Random phases, each with its own register setting and idling mix.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_regs(CFG_RESET, CFG_RESET, CFG_RESET);
        1: set_regs(12'd4095, 12'd1, 12'd3000);
        2: set_regs(12'd100, 12'd4095, 12'd16);
        3: set_regs(12'($urandom), 12'($urandom), 12'($urandom));
        default: set_regs(12'd0, 12'($urandom_range(64)), 12'($urandom_range(64)));
      endcase
      send_idle_pct = idle_set[ph % 4][0];
      stall_pct     = idle_set[ph % 4][1];
      if (ph == 0) begin
        // receiver stops for a long while so the input backs up
        fork
          begin
            hold_off <= 1'b1;
            repeat (HOLD_LEN) @(posedge clk_i);
            hold_off <= 1'b0;
          end
        join_none
      end
      for (int n = 0; n < 40; n++) random_line();
      drain();
    end
    send_idle_pct = 0;
    stall_pct     = 0;

    $display("covered %0d lines (%0d drawn as dots), %0d vertices checked",
             lines_sent, dots_seen, verts_seen);
    $display("register settings from zero to full scale, idle and stall mixes, long hold-off");
    if (errors == 0) begin
      $display("line_to_quad_expander test passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("line_to_quad_expander test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/lqe_pkg.sv
rtl/core/lqe_front.sv
rtl/core/lqe_fifo.sv
rtl/core/lqe_back.sv
rtl/core/line_to_quad_expander.sv
rtl/core/lqe_checker.sv
dv/tb_top.sv
